FILE: rtl/fsa_pkg.sv
// Shared constants, command codes, types and decode functions for the Forth stack datapath.
package fsa_pkg;

   localparam int DATA_DEPTH_DEF   = 64;
   localparam int RETURN_DEPTH_DEF = 64;
   localparam int WORD_BITS_DEF    = 32;

   localparam int CMD_BITS       = 6;
   localparam int LIT_BITS       = 32;
   localparam int TOP_BITS       = 32;
   localparam int DEPTH_OUT_BITS = 7;
   localparam int ERR_BITS       = 3;

   localparam logic [CMD_BITS-1:0] CMD_LIT      = 6'd0;
   localparam logic [CMD_BITS-1:0] CMD_DUP      = 6'd1;
   localparam logic [CMD_BITS-1:0] CMD_DROP     = 6'd2;
   localparam logic [CMD_BITS-1:0] CMD_OVER     = 6'd3;
   localparam logic [CMD_BITS-1:0] CMD_SWAP     = 6'd4;
   localparam logic [CMD_BITS-1:0] CMD_ROT      = 6'd5;
   localparam logic [CMD_BITS-1:0] CMD_PICK     = 6'd6;
   localparam logic [CMD_BITS-1:0] CMD_TO_R     = 6'd7;
   localparam logic [CMD_BITS-1:0] CMD_R_FROM   = 6'd8;
   localparam logic [CMD_BITS-1:0] CMD_R_FETCH  = 6'd9;
   localparam logic [CMD_BITS-1:0] CMD_TWO_DUP  = 6'd10;
   localparam logic [CMD_BITS-1:0] CMD_TWO_DROP = 6'd11;
   localparam logic [CMD_BITS-1:0] CMD_TWO_OVER = 6'd12;
   localparam logic [CMD_BITS-1:0] CMD_TWO_SWAP = 6'd13;
   localparam logic [CMD_BITS-1:0] CMD_ADD      = 6'd14;
   localparam logic [CMD_BITS-1:0] CMD_SUB      = 6'd15;
   localparam logic [CMD_BITS-1:0] CMD_MUL      = 6'd16;
   localparam logic [CMD_BITS-1:0] CMD_DIV      = 6'd17;
   localparam logic [CMD_BITS-1:0] CMD_MOD      = 6'd18;
   localparam logic [CMD_BITS-1:0] CMD_MUL_DIV  = 6'd19;
   localparam logic [CMD_BITS-1:0] CMD_MUL_DMOD = 6'd20;
   localparam logic [CMD_BITS-1:0] CMD_AND      = 6'd21;
   localparam logic [CMD_BITS-1:0] CMD_OR       = 6'd22;
   localparam logic [CMD_BITS-1:0] CMD_XOR      = 6'd23;
   localparam logic [CMD_BITS-1:0] CMD_NEGATE   = 6'd24;
   localparam logic [CMD_BITS-1:0] CMD_ABS      = 6'd25;
   localparam logic [CMD_BITS-1:0] CMD_MAX      = 6'd26;
   localparam logic [CMD_BITS-1:0] CMD_MIN      = 6'd27;
   localparam logic [CMD_BITS-1:0] CMD_TWO_MUL  = 6'd28;
   localparam logic [CMD_BITS-1:0] CMD_TWO_DIV  = 6'd29;
   localparam logic [CMD_BITS-1:0] CMD_INC      = 6'd30;
   localparam logic [CMD_BITS-1:0] CMD_DEC      = 6'd31;
   localparam logic [CMD_BITS-1:0] CMD_ZERO_EQ  = 6'd32;
   localparam logic [CMD_BITS-1:0] CMD_ZERO_LT  = 6'd33;
   localparam logic [CMD_BITS-1:0] CMD_ZERO_GT  = 6'd34;
   localparam logic [CMD_BITS-1:0] CMD_EQ       = 6'd35;
   localparam logic [CMD_BITS-1:0] CMD_GT       = 6'd36;
   localparam logic [CMD_BITS-1:0] CMD_LT       = 6'd37;
   localparam logic [CMD_BITS-1:0] CMD_NE       = 6'd38;
   localparam logic [CMD_BITS-1:0] CMD_GE       = 6'd39;
   localparam logic [CMD_BITS-1:0] CMD_LE       = 6'd40;
   localparam logic [CMD_BITS-1:0] CMD_DOT      = 6'd41;

   localparam logic [ERR_BITS-1:0] ERR_NONE  = 3'd0;
   localparam logic [ERR_BITS-1:0] ERR_UNDER = 3'd1;
   localparam logic [ERR_BITS-1:0] ERR_OVER  = 3'd2;
   localparam logic [ERR_BITS-1:0] ERR_DIVZ  = 3'd3;
   localparam logic [ERR_BITS-1:0] ERR_PICK  = 3'd4;

   typedef enum logic {MD_MUL, MD_DIV} md_op_type;

   typedef struct packed {
      logic      start;
      md_op_type op;
   } md_ctl_type;

   function automatic logic [2:0] fsa_need(input logic [CMD_BITS-1:0] cmd);
      logic [2:0] n;
      n = 3'd0;
      unique case (cmd)
         CMD_DUP, CMD_DROP, CMD_PICK, CMD_TO_R, CMD_NEGATE, CMD_ABS, CMD_TWO_MUL,
         CMD_TWO_DIV, CMD_INC, CMD_DEC, CMD_ZERO_EQ, CMD_ZERO_LT, CMD_ZERO_GT,
         CMD_DOT: n = 3'd1;
         CMD_OVER, CMD_SWAP, CMD_TWO_DUP, CMD_TWO_DROP, CMD_ADD, CMD_SUB, CMD_MUL,
         CMD_DIV, CMD_MOD, CMD_AND, CMD_OR, CMD_XOR, CMD_MAX, CMD_MIN, CMD_EQ,
         CMD_GT, CMD_LT, CMD_NE, CMD_GE, CMD_LE: n = 3'd2;
         CMD_ROT, CMD_MUL_DIV, CMD_MUL_DMOD: n = 3'd3;
         CMD_TWO_OVER, CMD_TWO_SWAP: n = 3'd4;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [1:0] fsa_grow(input logic [CMD_BITS-1:0] cmd);
      logic [1:0] g;
      g = 2'd0;
      unique case (cmd)
         CMD_LIT, CMD_DUP, CMD_OVER, CMD_R_FROM, CMD_R_FETCH: g = 2'd1;
         CMD_TWO_DUP, CMD_TWO_OVER: g = 2'd2;
         default: g = 2'd0;
      endcase
      return g;
   endfunction

endpackage

FILE: rtl/fsa_muldiv.sv
// Iterative shift-add multiplier and restoring signed divider shared by all mul/div words.
module fsa_muldiv
   import fsa_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  md_ctl_type           md_ctl,
   input  logic [WORD_BITS-1:0] md_x,
   input  logic [WORD_BITS-1:0] md_y,
   output logic                 md_done,
   output logic [WORD_BITS-1:0] md_prod,
   output logic [WORD_BITS-1:0] md_quot,
   output logic [WORD_BITS-1:0] md_rem
);

   localparam int CW = $clog2(WORD_BITS + 1);

   typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_FIX} mstate_type;

   mstate_type           state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] r1_ff, r1_in;
   logic [WORD_BITS-1:0] r2_ff, r2_in;
   logic [WORD_BITS-1:0] r3_ff, r3_in;
   logic                 xneg_ff, xneg_in;
   logic                 qneg_ff, qneg_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS:0]   trial;

   assign trial = {r1_ff, r3_ff[WORD_BITS-1]} - {1'b0, r2_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      r1_in    = r1_ff;
      r2_in    = r2_ff;
      r3_in    = r3_ff;
      xneg_in  = xneg_ff;
      qneg_in  = qneg_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         M_IDLE: begin
            if (md_ctl.start) begin
               r1_in  = '0;
               cnt_in = CW'(WORD_BITS);
               if (md_ctl.op == MD_MUL) begin
                  r2_in    = md_x;
                  r3_in    = md_y;
                  state_in = M_MUL;
               end else begin
                  r2_in    = md_y[WORD_BITS-1] ? (~md_y + 1'b1) : md_y;
                  r3_in    = md_x[WORD_BITS-1] ? (~md_x + 1'b1) : md_x;
                  xneg_in  = md_x[WORD_BITS-1];
                  qneg_in  = md_x[WORD_BITS-1] ^ md_y[WORD_BITS-1];
                  state_in = M_DIV;
               end
            end
         end
         M_MUL: begin
            if (r3_ff[0]) begin
               r1_in = r1_ff + r2_ff;
            end
            r2_in  = {r2_ff[WORD_BITS-2:0], 1'b0};
            r3_in  = {1'b0, r3_ff[WORD_BITS-1:1]};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               done_in  = 1'b1;
               state_in = M_IDLE;
            end
         end
         M_DIV: begin
            if (!trial[WORD_BITS]) begin
               r1_in = trial[WORD_BITS-1:0];
               r3_in = {r3_ff[WORD_BITS-2:0], 1'b1};
            end else begin
               r1_in = {r1_ff[WORD_BITS-2:0], r3_ff[WORD_BITS-1]};
               r3_in = {r3_ff[WORD_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = M_FIX;
            end
         end
         M_FIX: begin
            r3_in    = qneg_ff ? (~r3_ff + 1'b1) : r3_ff;
            r1_in    = xneg_ff ? (~r1_ff + 1'b1) : r1_ff;
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      r1_ff   <= r1_in;
      r2_ff   <= r2_in;
      r3_ff   <= r3_in;
      xneg_ff <= xneg_in;
      qneg_ff <= qneg_in;
   end

   assign md_done = done_ff;
   assign md_prod = r1_ff;
   assign md_quot = r3_ff;
   assign md_rem  = r1_ff;

endmodule

FILE: rtl/forth_stack_alu_core.sv
// Forth data-stack datapath: sequencer, top register, data and return stacks.
//
//   channel | ports                                          | dir
//   --------+------------------------------------------------+-----
//   request | req_valid/ready, req_command, req_literal_value | in
//   result  | rsp_valid/ready, rsp_top_value, rsp_stack_depth,| out
//           | rsp_printed_value, rsp_printed_valid,           |
//           | rsp_error_code                                  |
//
// One beat at a time. An error or an unused command goes straight to the result; any other word
// reads each operand below the top, fetches a pick or return-stack value if needed, runs the
// shared mul/div unit once or twice for mul/div words, stores each extra result word, and does
// a pop refill of the top when nothing is pushed. req_ready rises with rsp_valid. Reset clears
// top, both pointers and the sequencer; the stack memories are not.
// A finished result waits in the output register while the next beat is taken.
module forth_stack_alu_core
   import fsa_pkg::*;
#(
   parameter int DATA_DEPTH   = DATA_DEPTH_DEF,
   parameter int RETURN_DEPTH = RETURN_DEPTH_DEF,
   parameter int WORD_BITS    = WORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [CMD_BITS-1:0]               req_command,
   input  logic signed [LIT_BITS-1:0]        req_literal_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [TOP_BITS-1:0]        rsp_top_value,
   output logic [DEPTH_OUT_BITS-1:0]         rsp_stack_depth,
   output logic signed [TOP_BITS-1:0]        rsp_printed_value,
   output logic                              rsp_printed_valid,
   output logic [ERR_BITS-1:0]               rsp_error_code
);

   localparam int DPW = $clog2(DATA_DEPTH + 2);
   localparam int RPW = $clog2(RETURN_DEPTH + 1);
   localparam int DAW = $clog2(DATA_DEPTH);
   localparam int RAW = $clog2(RETURN_DEPTH);
   localparam int W   = WORD_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_CAP, S_AUX, S_EXEC, S_MD1, S_MD2, S_WR, S_POP, S_FIN
   } state_type;

   state_type            state_ff, state_in;
   logic [CMD_BITS-1:0]  cmd_ff, cmd_in;
   logic [W-1:0]         lit_ff, lit_in;
   logic [W-1:0]         top_ff, top_in;
   logic [DPW-1:0]       dp_ff, dp_in;
   logic [RPW-1:0]       rp_ff, rp_in;
   logic [W-1:0]         o_ff [4];
   logic [W-1:0]         o_in [4];
   logic [W-1:0]         res_ff [4];
   logic [W-1:0]         res_in [4];
   logic [W-1:0]         aux_ff, aux_in;
   logic [2:0]           k_ff, k_in;
   logic [2:0]           ld_ff, ld_in;
   logic [2:0]           pop_ff, pop_in;
   logic [2:0]           push_ff, push_in;
   logic [2:0]           m_ff, m_in;
   logic                 auxd_ff, auxd_in;
   logic                 auxr_ff, auxr_in;
   logic [DPW-1:0]       base_ff, base_in;
   logic [DPW-1:0]       wp_ff, wp_in;
   logic [ERR_BITS-1:0]  err_ff, err_in;
   logic [W-1:0]         prt_ff, prt_in;
   logic                 pv_ff, pv_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [TOP_BITS-1:0]       rsp_top_ff, rsp_top_in;
   logic [DEPTH_OUT_BITS-1:0] rsp_depth_ff, rsp_depth_in;
   logic [TOP_BITS-1:0]       rsp_prt_ff, rsp_prt_in;
   logic                      rsp_pv_ff, rsp_pv_in;
   logic [ERR_BITS-1:0]       rsp_err_ff, rsp_err_in;

   logic [W-1:0]   dstack_ff [DATA_DEPTH];
   logic [W-1:0]   rstack_ff [RETURN_DEPTH];
   logic [W-1:0]   drd_ff;
   logic [W-1:0]   rrd_ff;
   logic           d_we;
   logic [DAW-1:0] d_waddr;
   logic [W-1:0]   d_wdata;
   logic [DAW-1:0] d_raddr;
   logic           r_we;
   logic [RAW-1:0] r_raddr;

   md_ctl_type     md_ctl;
   logic [W-1:0]   md_x, md_y;
   logic           md_done;
   logic [W-1:0]   md_prod, md_quot, md_rem;

   logic                dec_known;
   logic [2:0]          dec_need;
   logic [1:0]          dec_grow;
   logic [ERR_BITS-1:0] dec_err;
   logic [DPW-1:0]      dp_m1;
   logic                nz;
   logic [W-1:0]        a_op, b_op, alu_y;
   logic                lt_ab, lt_ba;
   logic [W-1:0]        ones;

   fsa_muldiv #(.WORD_BITS(W)) u_muldiv (
      .clock   (clock),
      .reset   (reset),
      .md_ctl  (md_ctl),
      .md_x    (md_x),
      .md_y    (md_y),
      .md_done (md_done),
      .md_prod (md_prod),
      .md_quot (md_quot),
      .md_rem  (md_rem)
   );

   assign dp_m1     = dp_ff - DPW'(1);
   assign nz        = (dp_ff != '0);
   assign dec_known = (req_command <= CMD_DOT);
   assign dec_need  = fsa_need(req_command);
   assign dec_grow  = fsa_grow(req_command);
   assign ones      = '1;

   always_comb begin
      dec_err = ERR_NONE;
      priority if (!dec_known) begin
         dec_err = ERR_NONE;
      end else if (DPW'(dec_need) > dp_ff) begin
         dec_err = ERR_UNDER;
      end else if ((req_command == CMD_R_FROM || req_command == CMD_R_FETCH) &&
                   rp_ff == '0) begin
         dec_err = ERR_UNDER;
      end else if (dec_grow != 2'd0 &&
                   (int'(dp_ff) + int'(dec_grow)) > (DATA_DEPTH + 1)) begin
         dec_err = ERR_OVER;
      end else if (req_command == CMD_TO_R && int'(rp_ff) >= RETURN_DEPTH) begin
         dec_err = ERR_OVER;
      end else if ((req_command == CMD_DIV || req_command == CMD_MOD ||
                    req_command == CMD_MUL_DIV || req_command == CMD_MUL_DMOD) &&
                   top_ff == '0) begin
         dec_err = ERR_DIVZ;
      end else if (req_command == CMD_PICK) begin
         if (top_ff[W-1] || top_ff == '0) begin
            dec_err = ERR_PICK;
         end else if (top_ff > W'(dp_m1)) begin
            dec_err = ERR_UNDER;
         end
      end
   end

   assign a_op  = o_ff[1];
   assign b_op  = o_ff[0];
   assign lt_ab = ($signed(a_op) < $signed(b_op));
   assign lt_ba = ($signed(b_op) < $signed(a_op));

   always_comb begin
      alu_y = '0;
      unique case (cmd_ff)
         CMD_ADD:     alu_y = a_op + b_op;
         CMD_SUB:     alu_y = a_op - b_op;
         CMD_AND:     alu_y = a_op & b_op;
         CMD_OR:      alu_y = a_op | b_op;
         CMD_XOR:     alu_y = a_op ^ b_op;
         CMD_MAX:     alu_y = lt_ab ? b_op : a_op;
         CMD_MIN:     alu_y = lt_ba ? b_op : a_op;
         CMD_EQ:      alu_y = (a_op == b_op) ? ones : '0;
         CMD_GT:      alu_y = lt_ba ? ones : '0;
         CMD_LT:      alu_y = lt_ab ? ones : '0;
         CMD_NE:      alu_y = (a_op != b_op) ? ones : '0;
         CMD_GE:      alu_y = lt_ab ? '0 : ones;
         CMD_LE:      alu_y = lt_ba ? '0 : ones;
         CMD_NEGATE:  alu_y = '0 - b_op;
         CMD_ABS:     alu_y = b_op[W-1] ? ('0 - b_op) : b_op;
         CMD_TWO_MUL: alu_y = {b_op[W-2:0], 1'b0};
         CMD_TWO_DIV: alu_y = {b_op[W-1], b_op[W-1:1]};
         CMD_INC:     alu_y = b_op + 1'b1;
         CMD_DEC:     alu_y = b_op - 1'b1;
         CMD_ZERO_EQ: alu_y = (b_op == '0) ? ones : '0;
         CMD_ZERO_LT: alu_y = b_op[W-1] ? ones : '0;
         CMD_ZERO_GT: alu_y = (b_op != '0 && !b_op[W-1]) ? ones : '0;
         default:     alu_y = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      lit_in       = lit_ff;
      top_in       = top_ff;
      dp_in        = dp_ff;
      rp_in        = rp_ff;
      o_in         = o_ff;
      res_in       = res_ff;
      aux_in       = aux_ff;
      k_in         = k_ff;
      ld_in        = ld_ff;
      pop_in       = pop_ff;
      push_in      = push_ff;
      m_in         = m_ff;
      auxd_in      = auxd_ff;
      auxr_in      = auxr_ff;
      base_in      = base_ff;
      wp_in        = wp_ff;
      err_in       = err_ff;
      prt_in       = prt_ff;
      pv_in        = pv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_top_in   = rsp_top_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_prt_in   = rsp_prt_ff;
      rsp_pv_in    = rsp_pv_ff;
      rsp_err_in   = rsp_err_ff;
      d_we         = 1'b0;
      d_waddr      = wp_ff[DAW-1:0];
      d_wdata      = res_ff[0];
      d_raddr      = DAW'(dp_m1 - DPW'(k_ff));
      r_we         = 1'b0;
      r_raddr      = RAW'(rp_ff - RPW'(1));
      md_ctl.start = 1'b0;
      md_ctl.op    = MD_MUL;
      md_x         = o_ff[1];
      md_y         = o_ff[0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_command;
               lit_in  = W'(req_literal_value);
               o_in[0] = top_ff;
               k_in    = 3'd1;
               err_in  = dec_err;
               prt_in  = '0;
               pv_in   = 1'b0;
               auxd_in = 1'b0;
               auxr_in = 1'b0;
               ld_in   = 3'd1;
               pop_in  = 3'd1;
               push_in = 3'd1;
               unique case (req_command)
                  CMD_LIT, CMD_R_FROM, CMD_R_FETCH: begin
                     ld_in   = {2'b00, nz};
                     pop_in  = {2'b00, nz};
                     push_in = {2'b00, nz} + 3'd1;
                     auxr_in = (req_command != CMD_LIT);
                  end
                  CMD_DUP:  push_in = 3'd2;
                  CMD_DROP, CMD_TO_R, CMD_DOT: push_in = 3'd0;
                  CMD_OVER: begin
                     ld_in   = 3'd2;
                     push_in = 3'd2;
                  end
                  CMD_SWAP: begin
                     ld_in   = 3'd2;
                     pop_in  = 3'd2;
                     push_in = 3'd2;
                  end
                  CMD_ROT: begin
                     ld_in   = 3'd3;
                     pop_in  = 3'd3;
                     push_in = 3'd3;
                  end
                  CMD_PICK: auxd_in = 1'b1;
                  CMD_TWO_DUP: begin
                     ld_in   = 3'd2;
                     pop_in  = 3'd2;
                     push_in = 3'd4;
                  end
                  CMD_TWO_DROP: begin
                     ld_in   = 3'd2;
                     pop_in  = 3'd2;
                     push_in = 3'd0;
                  end
                  CMD_TWO_OVER: begin
                     ld_in   = 3'd4;
                     pop_in  = 3'd2;
                     push_in = 3'd4;
                  end
                  CMD_TWO_SWAP: begin
                     ld_in   = 3'd4;
                     pop_in  = 3'd4;
                     push_in = 3'd4;
                  end
                  CMD_MUL_DIV: begin
                     ld_in  = 3'd3;
                     pop_in = 3'd3;
                  end
                  CMD_MUL_DMOD: begin
                     ld_in   = 3'd3;
                     pop_in  = 3'd3;
                     push_in = 3'd2;
                  end
                  CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_AND, CMD_OR,
                  CMD_XOR, CMD_MAX, CMD_MIN, CMD_EQ, CMD_GT, CMD_LT, CMD_NE,
                  CMD_GE, CMD_LE: begin
                     ld_in  = 3'd2;
                     pop_in = 3'd2;
                  end
                  default: ld_in = 3'd1;
               endcase
               if (!dec_known || dec_err != ERR_NONE) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (k_ff < ld_ff) begin
               state_in = S_CAP;
            end else if (auxd_ff || auxr_ff) begin
               d_raddr  = DAW'(dp_m1 - DPW'(top_ff));
               state_in = S_AUX;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_CAP: begin
            o_in[k_ff[1:0]] = drd_ff;
            k_in            = k_ff + 3'd1;
            state_in        = S_RD;
         end
         S_AUX: begin
            aux_in   = auxd_ff ? drd_ff : rrd_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            base_in  = dp_ff - DPW'(pop_ff);
            wp_in    = dp_ff - DPW'(pop_ff);
            dp_in    = dp_ff - DPW'(pop_ff) + DPW'(push_ff);
            m_in     = push_ff;
            state_in = S_WR;
            res_in[0] = alu_y;
            unique case (cmd_ff)
               CMD_LIT, CMD_R_FROM, CMD_R_FETCH: begin
                  if (nz) begin
                     res_in[0] = o_ff[0];
                     res_in[1] = (cmd_ff == CMD_LIT) ? lit_ff : aux_ff;
                  end else begin
                     res_in[0] = (cmd_ff == CMD_LIT) ? lit_ff : aux_ff;
                  end
                  if (cmd_ff == CMD_R_FROM) begin
                     rp_in = rp_ff - RPW'(1);
                  end
               end
               CMD_DUP: begin
                  res_in[0] = o_ff[0];
                  res_in[1] = o_ff[0];
               end
               CMD_OVER, CMD_SWAP: begin
                  res_in[0] = o_ff[0];
                  res_in[1] = o_ff[1];
               end
               CMD_ROT: begin
                  res_in[0] = o_ff[1];
                  res_in[1] = o_ff[0];
                  res_in[2] = o_ff[2];
               end
               CMD_PICK: res_in[0] = aux_ff;
               CMD_TO_R: begin
                  r_we  = 1'b1;
                  rp_in = rp_ff + RPW'(1);
               end
               CMD_TWO_DUP: begin
                  res_in[0] = o_ff[1];
                  res_in[1] = o_ff[0];
                  res_in[2] = o_ff[1];
                  res_in[3] = o_ff[0];
               end
               CMD_TWO_OVER, CMD_TWO_SWAP: begin
                  res_in[0] = o_ff[1];
                  res_in[1] = o_ff[0];
                  res_in[2] = o_ff[3];
                  res_in[3] = o_ff[2];
               end
               CMD_DOT: begin
                  prt_in = o_ff[0];
                  pv_in  = 1'b1;
               end
               CMD_MUL: begin
                  md_ctl.start = 1'b1;
                  state_in     = S_MD2;
               end
               CMD_DIV, CMD_MOD: begin
                  md_ctl.start = 1'b1;
                  md_ctl.op    = MD_DIV;
                  state_in     = S_MD2;
               end
               CMD_MUL_DIV, CMD_MUL_DMOD: begin
                  md_ctl.start = 1'b1;
                  md_x         = o_ff[2];
                  md_y         = o_ff[1];
                  state_in     = S_MD1;
               end
               default: res_in[0] = alu_y;
            endcase
         end
         S_MD1: begin
            md_x      = md_prod;
            md_y      = o_ff[0];
            md_ctl.op = MD_DIV;
            if (md_done) begin
               md_ctl.start = 1'b1;
               state_in     = S_MD2;
            end
         end
         S_MD2: begin
            if (md_done) begin
               unique case (cmd_ff)
                  CMD_MUL: res_in[0] = md_prod;
                  CMD_MOD: res_in[0] = md_rem;
                  CMD_MUL_DMOD: begin
                     res_in[0] = md_rem;
                     res_in[1] = md_quot;
                  end
                  default: res_in[0] = md_quot;
               endcase
               state_in = S_WR;
            end
         end
         S_WR: begin
            priority if (m_ff == 3'd0) begin
               d_raddr = DAW'(base_ff - DPW'(1));
               if (base_ff != '0) begin
                  state_in = S_POP;
               end else begin
                  top_in   = '0;
                  state_in = S_FIN;
               end
            end else if (m_ff == 3'd1) begin
               top_in   = res_ff[0];
               state_in = S_FIN;
            end else begin
               d_we      = 1'b1;
               wp_in     = wp_ff + DPW'(1);
               res_in[0] = res_ff[1];
               res_in[1] = res_ff[2];
               res_in[2] = res_ff[3];
               m_in      = m_ff - 3'd1;
            end
         end
         S_POP: begin
            top_in   = drd_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_top_in   = TOP_BITS'(top_ff);
               rsp_depth_in = DEPTH_OUT_BITS'(dp_ff);
               rsp_prt_in   = TOP_BITS'(prt_ff);
               rsp_pv_in    = pv_ff;
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         dp_ff        <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         dp_ff        <= dp_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      lit_ff       <= lit_in;
      o_ff         <= o_in;
      res_ff       <= res_in;
      aux_ff       <= aux_in;
      k_ff         <= k_in;
      ld_ff        <= ld_in;
      pop_ff       <= pop_in;
      push_ff      <= push_in;
      m_ff         <= m_in;
      auxd_ff      <= auxd_in;
      auxr_ff      <= auxr_in;
      base_ff      <= base_in;
      wp_ff        <= wp_in;
      err_ff       <= err_in;
      prt_ff       <= prt_in;
      pv_ff        <= pv_in;
      rsp_top_ff   <= rsp_top_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_prt_ff   <= rsp_prt_in;
      rsp_pv_ff    <= rsp_pv_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         dstack_ff[d_waddr] <= d_wdata;
      end
      drd_ff <= dstack_ff[d_raddr];
   end

   always_ff @(posedge clock) begin
      if (r_we) begin
         rstack_ff[rp_ff[RAW-1:0]] <= o_ff[0];
      end
      rrd_ff <= rstack_ff[r_raddr];
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_top_value     = rsp_top_ff;
   assign rsp_stack_depth   = rsp_depth_ff;
   assign rsp_printed_value = rsp_prt_ff;
   assign rsp_printed_valid = rsp_pv_ff;
   assign rsp_error_code    = rsp_err_ff;

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a beat is in flight");

   a_dp_bound: assert property (@(posedge clock) disable iff (reset)
      int'(dp_ff) <= DATA_DEPTH + 1)
      else $error("data pointer out of range");

   a_rp_bound: assert property (@(posedge clock) disable iff (reset)
      int'(rp_ff) <= RETURN_DEPTH)
      else $error("return pointer out of range");

   a_err_no_print: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |-> !rsp_printed_valid)
      else $error("printed value flagged on a failed beat");

endmodule

FILE: verif/tb_top.sv
// Testbench for forth_stack_alu_core: queued stimulus, bursty driver, stalling monitor, predictor.
module tb_top;
   import fsa_pkg::*;

   localparam int DEPTH   = 64;
   localparam int RDEPTH  = 64;
   localparam int NRAND   = 1300;
   localparam int WD_MAX  = 3000;
   localparam int TAIL    = 200;

   typedef struct {
      logic [CMD_BITS-1:0] cmd;
      logic [31:0]         lit;
      bit                  hold;
   } beat_type;

   typedef struct {
      logic [31:0]               top;
      logic [DEPTH_OUT_BITS-1:0] depth;
      logic [31:0]               printed;
      logic                      pvalid;
      logic [ERR_BITS-1:0]       err;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CMD_BITS-1:0] req_command = '0;
   logic signed [LIT_BITS-1:0] req_literal_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [TOP_BITS-1:0] rsp_top_value;
   logic [DEPTH_OUT_BITS-1:0] rsp_stack_depth;
   logic signed [TOP_BITS-1:0] rsp_printed_value;
   logic rsp_printed_valid;
   logic [ERR_BITS-1:0] rsp_error_code;

   beat_type    pending[$];
   outcome_type expected[$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   int          gap_left = 0;
   int          burst_left = 4;
   int          cycle_count = 0;

   // predictor state
   logic [31:0] top_reg;
   logic [31:0] data_mem[DEPTH];
   int          dp;
   logic [31:0] ret_mem[RDEPTH];
   int          rp;

   always #5 clock = ~clock;

   forth_stack_alu_core u_top (.*);

   task automatic report(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic logic [31:0] peek(input int k);
      if (k == 0) return top_reg;
      if (k < dp && dp - 1 - k < DEPTH) return data_mem[dp - 1 - k];
      return '0;
   endfunction

   function automatic logic [31:0] pop_word();
      logic [31:0] v;
      v = top_reg;
      top_reg = (dp >= 2 && dp - 2 < DEPTH) ? data_mem[dp - 2] : '0;
      if (dp > 0) dp--;
      return v;
   endfunction

   function automatic void push_word(input logic [31:0] v);
      if (dp >= 1 && dp - 1 < DEPTH) data_mem[dp - 1] = top_reg;
      top_reg = v;
      dp++;
   endfunction

   function automatic logic [31:0] mag(input logic [31:0] a);
      return a[31] ? -a : a;
   endfunction

   function automatic logic [31:0] quotient(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] q;
      q = mag(a) / mag(b);
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic logic [31:0] remainder(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] r;
      r = mag(a) % mag(b);
      return a[31] ? -r : r;
   endfunction

   function automatic logic [31:0] flag(input bit f);
      return f ? 32'hFFFF_FFFF : 32'h0;
   endfunction

   function automatic int operands_of(input logic [CMD_BITS-1:0] c);
      case (c)
         CMD_DUP, CMD_DROP, CMD_PICK, CMD_TO_R, CMD_NEGATE, CMD_ABS, CMD_TWO_MUL,
         CMD_TWO_DIV, CMD_INC, CMD_DEC, CMD_ZERO_EQ, CMD_ZERO_LT, CMD_ZERO_GT,
         CMD_DOT: return 1;
         CMD_ROT, CMD_MUL_DIV, CMD_MUL_DMOD: return 3;
         CMD_TWO_OVER, CMD_TWO_SWAP: return 4;
         CMD_LIT, CMD_R_FROM, CMD_R_FETCH: return 0;
         default: return (c <= CMD_DOT) ? 2 : 0;
      endcase
   endfunction

   function automatic int growth_of(input logic [CMD_BITS-1:0] c);
      case (c)
         CMD_LIT, CMD_DUP, CMD_OVER, CMD_R_FROM, CMD_R_FETCH: return 1;
         CMD_TWO_DUP, CMD_TWO_OVER: return 2;
         default: return 0;
      endcase
   endfunction

   function automatic outcome_type execute(input logic [CMD_BITS-1:0] c,
                                           input logic [31:0] lit);
      outcome_type o;
      logic [31:0] a, b, x, d, p;
      o.printed = '0;
      o.pvalid = 1'b0;
      o.err = ERR_NONE;
      if (c <= CMD_DOT) begin
         if (dp < operands_of(c)) o.err = ERR_UNDER;
         else if ((c == CMD_R_FROM || c == CMD_R_FETCH) && rp == 0) o.err = ERR_UNDER;
         else if (dp + growth_of(c) > DEPTH + 1) o.err = ERR_OVER;
         else if (c == CMD_TO_R && rp >= RDEPTH) o.err = ERR_OVER;
         else if ((c == CMD_DIV || c == CMD_MOD || c == CMD_MUL_DIV || c == CMD_MUL_DMOD)
                  && top_reg == 0) o.err = ERR_DIVZ;
         else if (c == CMD_PICK) begin
            if (top_reg[31] || top_reg == 0) o.err = ERR_PICK;
            else if (longint'(top_reg) > dp - 1) o.err = ERR_UNDER;
         end
      end
      if (o.err == ERR_NONE && c <= CMD_DOT) begin
         case (c)
            CMD_LIT:      push_word(lit);
            CMD_DUP:      push_word(top_reg);
            CMD_DROP:     p = pop_word();
            CMD_OVER:     push_word(peek(1));
            CMD_SWAP: begin
               b = pop_word(); a = pop_word(); push_word(b); push_word(a);
            end
            CMD_ROT: begin
               x = pop_word(); b = pop_word(); a = pop_word();
               push_word(b); push_word(x); push_word(a);
            end
            CMD_PICK:     top_reg = peek(int'(top_reg));
            CMD_TO_R: begin
               ret_mem[rp] = pop_word(); rp++;
            end
            CMD_R_FROM: begin
               rp--; push_word(ret_mem[rp]);
            end
            CMD_R_FETCH:  push_word(ret_mem[rp - 1]);
            CMD_TWO_DUP: begin
               push_word(peek(1)); push_word(peek(1));
            end
            CMD_TWO_DROP: begin
               p = pop_word(); p = pop_word();
            end
            CMD_TWO_OVER: begin
               push_word(peek(3)); push_word(peek(3));
            end
            CMD_TWO_SWAP: begin
               d = pop_word(); x = pop_word(); b = pop_word(); a = pop_word();
               push_word(x); push_word(d); push_word(a); push_word(b);
            end
            CMD_MUL_DIV, CMD_MUL_DMOD: begin
               x = pop_word(); b = pop_word(); a = pop_word();
               a = a * b;
               if (c == CMD_MUL_DMOD) push_word(remainder(a, x));
               push_word(quotient(a, x));
            end
            CMD_NEGATE:   top_reg = -top_reg;
            CMD_ABS:      top_reg = mag(top_reg);
            CMD_TWO_MUL:  top_reg = top_reg << 1;
            CMD_TWO_DIV:  top_reg = {top_reg[31], top_reg[31:1]};
            CMD_INC:      top_reg = top_reg + 1;
            CMD_DEC:      top_reg = top_reg - 1;
            CMD_ZERO_EQ:  top_reg = flag(top_reg == 0);
            CMD_ZERO_LT:  top_reg = flag(top_reg[31]);
            CMD_ZERO_GT:  top_reg = flag(top_reg != 0 && !top_reg[31]);
            CMD_DOT: begin
               o.printed = pop_word(); o.pvalid = 1'b1;
            end
            default: begin
               b = pop_word(); a = pop_word();
               case (c)
                  CMD_ADD: x = a + b;
                  CMD_SUB: x = a - b;
                  CMD_MUL: x = a * b;
                  CMD_DIV: x = quotient(a, b);
                  CMD_MOD: x = remainder(a, b);
                  CMD_AND: x = a & b;
                  CMD_OR:  x = a | b;
                  CMD_XOR: x = a ^ b;
                  CMD_MAX: x = ($signed(a) < $signed(b)) ? b : a;
                  CMD_MIN: x = ($signed(b) < $signed(a)) ? b : a;
                  CMD_EQ:  x = flag(a == b);
                  CMD_GT:  x = flag($signed(b) < $signed(a));
                  CMD_LT:  x = flag($signed(a) < $signed(b));
                  CMD_NE:  x = flag(a != b);
                  CMD_GE:  x = flag(!($signed(a) < $signed(b)));
                  default: x = flag(!($signed(b) < $signed(a)));
               endcase
               push_word(x);
            end
         endcase
      end
      o.top = top_reg;
      o.depth = dp[DEPTH_OUT_BITS-1:0];
      return o;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 6);
         1: return -$urandom_range(1, 4);
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic void add(input logic [CMD_BITS-1:0] c, input logic [31:0] v,
                               input bit h = 1'b0);
      beat_type t;
      t.cmd = c;
      t.lit = v;
      t.hold = h;
      pending.push_back(t);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         top_reg = '0;
         dp = 0;
         rp = 0;
      end else begin
         if (req_valid && req_ready)
            expected.push_back(execute(req_command, req_literal_value));
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending.size() > 0 && !(pending[0].hold && expected.size() > 0)) begin
               req_valid <= 1'b1;
               req_command <= pending[0].cmd;
               req_literal_value <= pending[0].lit;
               pending.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         cycle_count++;
         case ((cycle_count / 150) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= cycle_count[0];
         endcase
         if (rsp_valid && rsp_ready) begin
            if (expected.size() == 0) begin
               report("result with nothing expected");
            end else begin
               e = expected.pop_front();
               if (rsp_top_value !== e.top)
                  report($sformatf("top %h, want %h", rsp_top_value, e.top));
               if (rsp_stack_depth !== e.depth)
                  report($sformatf("depth %0d, want %0d", rsp_stack_depth, e.depth));
               if (rsp_printed_value !== e.printed)
                  report($sformatf("printed %h, want %h", rsp_printed_value, e.printed));
               if (rsp_printed_valid !== e.pvalid)
                  report($sformatf("printed_valid %b, want %b", rsp_printed_valid, e.pvalid));
               if (rsp_error_code !== e.err)
                  report($sformatf("error %0d, want %0d", rsp_error_code, e.err));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WD_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int n;
      int r;
      int k;
      add(CMD_DROP, 0);
      add(CMD_R_FROM, 0);
      add(CMD_LIT, 32'h7FFF_FFFF);
      add(CMD_LIT, 32'h8000_0000);
      add(CMD_LIT, 32'hFFFF_FFFF);
      add(CMD_DIV, 0);
      add(CMD_TWO_DIV, 0);
      add(CMD_NEGATE, 0);
      add(CMD_LIT, 0);
      add(CMD_MOD, 0);
      add(CMD_PICK, 0);
      add(CMD_LIT, 32'hFFFF_FFFD);
      add(CMD_PICK, 0);
      add(CMD_LIT, 1);
      add(CMD_PICK, 0);
      add(CMD_LIT, 40);
      add(CMD_PICK, 0);
      add(CMD_TO_R, 0);
      add(CMD_R_FETCH, 0);
      add(CMD_R_FROM, 0);
      add(CMD_TWO_DUP, 0);
      add(CMD_TWO_OVER, 0);
      add(CMD_TWO_SWAP, 0);
      add(CMD_MUL_DMOD, 0);
      add(6'd50, 0);
      add(CMD_DOT, 0, 1'b1);
      n = 0;
      while (n < NRAND) begin
         r = $urandom_range(0, 199);
         if (r < 2) begin
            for (k = 0; k < 68; k++) add(CMD_LIT, pick_value());
            n += 68;
         end else if (r < 4) begin
            for (k = 0; k < 66; k++) begin
               add(CMD_LIT, $urandom);
               add(CMD_TO_R, 0);
            end
            for (k = 0; k < 66; k++) add(CMD_R_FROM, 0);
            n += 198;
         end else if (r < 80) begin
            add(CMD_LIT, pick_value());
            n++;
         end else if (r < 90) begin
            add(CMD_BITS'($urandom_range(CMD_DOT + 1, 63)), $urandom);
         end else begin
            add(CMD_BITS'($urandom_range(1, CMD_DOT)), $urandom, n == NRAND / 2);
            n++;
         end
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (pending.size() == 0 && !req_valid && expected.size() == 0);
      repeat (TAIL) @(posedge clock);
      if (expected.size() != 0) report("results never arrived");
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
